// ----- sv/pecs_pkg.sv -----
// Shared types, constants and configuration codes of the polygon edge clip stage.
package pecs_pkg;

    // Coordinate width of vertices and of the clip boundary.
    localparam int COORD_WIDTH = 16;

    // Configuration port: register index and data widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Bit-serial steps per multiply and per divide, and the step counter width.
    localparam int SERIAL_STEPS = COORD_WIDTH + 1;
    localparam int CNT_W        = $clog2(SERIAL_STEPS);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COORD_WIDTH:0]   t_diff;
    typedef logic        [COORD_WIDTH:0]   t_mag;

    // Which side of the boundary is kept.
    typedef enum logic [1:0] {
        EDGE_BOTTOM = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_TOP    = 2'd2,
        EDGE_LEFT   = 2'd3
    } t_edge_kind;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_KIND  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COORD = 1'b1;

    localparam logic [CFG_DATA_W-1:0] EDGE_COORD_RESET = 16'd100;

    // Request to the crossing unit: base + a * b / d.
    typedef struct packed {
        logic   start;
        t_coord base;
        t_diff  a;
        t_diff  b;
        t_diff  d;
    } t_lerp_req;

    // Status of the crossing unit.
    typedef struct packed {
        logic   done;
        t_coord result;
    } t_lerp_sts;

endpackage

// ----- sv/pecs_lerp.sv -----
// Bit-serial crossing unit: base + a * b / d with the quotient truncated toward zero.
module pecs_lerp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pecs_pkg::t_lerp_req i_req,
    output pecs_pkg::t_lerp_sts o_sts
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } t_lstate;

    t_lstate                              r_state;
    logic [pecs_pkg::CNT_W-1:0]           r_cnt;
    pecs_pkg::t_mag                       r_ma;
    pecs_pkg::t_mag                       r_md;
    logic [pecs_pkg::COORD_WIDTH+1:0]     r_hi;
    pecs_pkg::t_mag                       r_lo;
    logic                                 r_neg;
    pecs_pkg::t_coord                     r_base;
    logic                                 r_done;
    pecs_pkg::t_coord                     r_result;

    logic [pecs_pkg::COORD_WIDTH+1:0]     mul_sum;
    logic [pecs_pkg::COORD_WIDTH+1:0]     div_trial;
    logic [pecs_pkg::COORD_WIDTH+2:0]     div_diff;
    logic                                 div_ge;
    logic                                 last_step;
    pecs_pkg::t_coord                     quot;

    // Magnitude of a signed difference.
    function automatic pecs_pkg::t_mag mag(pecs_pkg::t_diff v);
        return v[pecs_pkg::COORD_WIDTH] ? pecs_pkg::t_mag'(-v) : pecs_pkg::t_mag'(v);
    endfunction

    // Shift-add step: add the multiplicand when the low multiplier bit is set.
    assign mul_sum = r_hi + {1'b0, (r_lo[0] ? r_ma : '0)};

    // Restoring division step: shift in the next dividend bit and try a subtract.
    assign div_trial = {r_hi[pecs_pkg::COORD_WIDTH:0], r_lo[pecs_pkg::COORD_WIDTH]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, r_md};
    assign div_ge    = !div_diff[pecs_pkg::COORD_WIDTH+2];

    assign last_step = (r_cnt == pecs_pkg::CNT_W'(pecs_pkg::SERIAL_STEPS - 1));

    // Only the low coordinate bits of the quotient matter after wrapping.
    assign quot = pecs_pkg::t_coord'(r_lo[pecs_pkg::COORD_WIDTH-1:0]);

    // Sequencer: load, multiply one bit a cycle, divide one bit a cycle, then add.
    // The product stays in {r_hi, r_lo}; its upper part is the starting remainder,
    // which is already below the divisor because the quotient never exceeds |b|.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_req.start) begin
                        r_ma    <= mag(i_req.a);
                        r_lo    <= mag(i_req.b);
                        r_md    <= mag(i_req.d);
                        r_hi    <= '0;
                        r_neg   <= i_req.a[pecs_pkg::COORD_WIDTH]
                                 ^ i_req.b[pecs_pkg::COORD_WIDTH]
                                 ^ i_req.d[pecs_pkg::COORD_WIDTH];
                        r_base  <= i_req.base;
                        r_cnt   <= '0;
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    {r_hi, r_lo} <= {mul_sum, r_lo} >> 1;
                    if (last_step) begin
                        r_cnt   <= '0;
                        r_state <= L_DIV;
                    end else begin
                        r_cnt <= r_cnt + pecs_pkg::CNT_W'(1);
                    end
                end
                L_DIV: begin
                    r_hi <= div_ge ? div_diff[pecs_pkg::COORD_WIDTH+1:0] : div_trial;
                    r_lo <= {r_lo[pecs_pkg::COORD_WIDTH-1:0], div_ge};
                    if (last_step) begin
                        r_state <= L_FIN;
                    end else begin
                        r_cnt <= r_cnt + pecs_pkg::CNT_W'(1);
                    end
                end
                L_FIN: begin
                    r_result <= r_neg ? r_base - quot : r_base + quot;
                    r_done   <= 1'b1;
                    r_state  <= L_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.result = r_result;

endmodule

// ----- sv/polygon_edge_clip_stage.sv -----
// Top level of one Sutherland-Hodgman clipping stage against an axis-aligned boundary.
//
// Vertices arrive one per input transfer; a priming vertex sets the edge start and
// yields nothing. A priming vertex, or a vertex whose edge lies wholly on one side,
// is handled directly in ST_IDLE. For an edge that crosses the boundary, the crossing
// is computed by the bit-serial shift-add multiplier and restoring divider in
// pecs_lerp, each of which handles one bit per cycle. The input stalls while a result
// waits to be taken, so a vertex never overlaps the results of the one before it.
// Configuration writes are always ready and are meant for idle periods only.
module polygon_edge_clip_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Vertex input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pecs_pkg::t_coord                   i_vertex_x,
    input  pecs_pkg::t_coord                   i_vertex_y,
    input  logic                               i_prime,
    // Clipped vertex output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pecs_pkg::t_coord                   o_out_x,
    output pecs_pkg::t_coord                   o_out_y,
    output logic                               o_last_of_run,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pecs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pecs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_SECOND
    } t_state;

    t_state                                r_state;
    pecs_pkg::t_edge_kind                  r_edge_kind;
    logic [pecs_pkg::CFG_DATA_W-1:0]       r_edge_coord;
    pecs_pkg::t_coord                      r_start_x;
    pecs_pkg::t_coord                      r_start_y;
    pecs_pkg::t_coord                      r_px;
    pecs_pkg::t_coord                      r_py;
    logic                                  r_p_in;
    logic                                  r_x_fixed;
    pecs_pkg::t_coord                      r_base;
    pecs_pkg::t_diff                       r_a;
    pecs_pkg::t_diff                       r_b;
    pecs_pkg::t_diff                       r_d;
    logic                                  r_out_valid;
    pecs_pkg::t_coord                      r_out_x;
    pecs_pkg::t_coord                      r_out_y;
    logic                                  r_last;

    pecs_pkg::t_coord                      coord;
    logic                                  s_in;
    logic                                  p_in;
    logic                                  in_xfer;
    logic                                  out_xfer;
    pecs_pkg::t_lerp_req                   lerp_req;
    pecs_pkg::t_lerp_sts                   lerp_sts;

    // True when a point lies on the kept side of the boundary.
    function automatic logic is_inside(pecs_pkg::t_coord x, pecs_pkg::t_coord y,
                                       pecs_pkg::t_coord c, pecs_pkg::t_edge_kind kind);
        logic res;
        unique case (kind)
            pecs_pkg::EDGE_BOTTOM: res = (y >= c);
            pecs_pkg::EDGE_RIGHT:  res = (x <= c);
            pecs_pkg::EDGE_TOP:    res = (y <= c);
            pecs_pkg::EDGE_LEFT:   res = (x >= c);
        endcase
        return res;
    endfunction

    // Signed difference one bit wider than the coordinates.
    function automatic pecs_pkg::t_diff diff(pecs_pkg::t_coord x, pecs_pkg::t_coord y);
        return pecs_pkg::t_diff'(x) - pecs_pkg::t_diff'(y);
    endfunction

    // Boundary coordinate at the working width.
    assign coord = pecs_pkg::t_coord'($signed(r_edge_coord));

    assign s_in = is_inside(r_start_x, r_start_y, coord, r_edge_kind);
    assign p_in = is_inside(i_vertex_x, i_vertex_y, coord, r_edge_kind);

    // Handshakes.
    assign o_in_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_kind  <= pecs_pkg::EDGE_BOTTOM;
            r_edge_coord <= pecs_pkg::EDGE_COORD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pecs_pkg::CFG_EDGE_KIND:  r_edge_kind  <= pecs_pkg::t_edge_kind'(i_cfg_data[1:0]);
                pecs_pkg::CFG_EDGE_COORD: r_edge_coord <= i_cfg_data;
            endcase
        end
    end

    // Operands for the crossing unit, started for one cycle in ST_LAUNCH.
    assign lerp_req.start = (r_state == ST_LAUNCH);
    assign lerp_req.base  = r_base;
    assign lerp_req.a     = r_a;
    assign lerp_req.b     = r_b;
    assign lerp_req.d     = r_d;

    pecs_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lerp_req),
        .o_sts   (lerp_sts)
    );

    // Edge sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_start_x   <= '0;
            r_start_y   <= '0;
        end else begin
            // In ST_SECOND the transfer of the crossing loads the vertex that follows it.
            if (out_xfer && r_state != ST_SECOND) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_start_x <= i_vertex_x;
                        r_start_y <= i_vertex_y;
                        if (!i_prime) begin
                            r_px      <= i_vertex_x;
                            r_py      <= i_vertex_y;
                            r_p_in    <= p_in;
                            r_x_fixed <= r_edge_kind[0];
                            // Bottom and top solve for x; right and left solve for y.
                            if (!r_edge_kind[0]) begin
                                r_base <= r_start_x;
                                r_a    <= diff(coord, r_start_y);
                                r_b    <= diff(i_vertex_x, r_start_x);
                                r_d    <= diff(i_vertex_y, r_start_y);
                            end else begin
                                r_base <= r_start_y;
                                r_a    <= diff(coord, r_start_x);
                                r_b    <= diff(i_vertex_y, r_start_y);
                                r_d    <= diff(i_vertex_x, r_start_x);
                            end
                            if (p_in && s_in) begin
                                r_out_valid <= 1'b1;
                                r_out_x     <= i_vertex_x;
                                r_out_y     <= i_vertex_y;
                                r_last      <= 1'b1;
                            end else if (p_in != s_in) begin
                                r_state <= ST_LAUNCH;
                            end
                        end
                    end
                end
                ST_LAUNCH: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    // The crossing is last unless the new vertex follows it.
                    if (lerp_sts.done) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_x_fixed ? coord : lerp_sts.result;
                        r_out_y     <= r_x_fixed ? lerp_sts.result : coord;
                        r_last      <= !r_p_in;
                        r_state     <= r_p_in ? ST_SECOND : ST_IDLE;
                    end
                end
                ST_SECOND: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_px;
                        r_out_y     <= r_py;
                        r_last      <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_last_of_run = r_last;

endmodule

// ----- sv/pecs_checker.sv -----
// Port-level checker for the polygon edge clip stage, with its bind to the top level.
module pecs_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  logic                               i_prime,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  pecs_pkg::t_coord                   o_out_x,
    input  pecs_pkg::t_coord                   o_out_y,
    input  logic                               o_last_of_run
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // A vertex is never taken while a result of the previous one is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> !o_out_valid)
        else $error("input transfer while a result is pending");

    // A priming vertex produces no result.
    a_prime_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_prime |=> !o_out_valid)
        else $error("priming vertex produced a result");

    // A result that is not the last of its run is followed at once by another.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !o_last_of_run |=> o_out_valid)
        else $error("second result of a run missing");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_x)
            && $stable(o_out_y) && $stable(o_last_of_run))
        else $error("stalled result changed");

endmodule

bind polygon_edge_clip_stage pecs_checker u_pecs_checker (.*);
